@@ design/knn_pkg.sv @@
// Package for the k-nearest-neighbor classifier: transfer payload types, action and
// register codes, controller states and elaboration helpers.
// No dependencies.
`default_nettype none
package knn_pkg;

   localparam int DEF_MAX_SAMPLES  = 1024;
   localparam int DEF_MAX_FEATURES = 64;
   localparam int DEF_MAX_K        = 16;
   localparam int DEF_NUM_CLASSES  = 16;
   localparam int DEF_FEATURE_BITS = 16;

   localparam int K_REG_BITS   = 5;
   localparam int FC_REG_BITS  = 7;
   localparam int CSR_DATA_BITS = 7;
   localparam int LABEL_SLOT   = 8;
   localparam int LABEL_IN_BITS = 4;
   localparam int DRAIN_BITS   = 2;
   localparam logic [DRAIN_BITS-1:0] DRAIN_LAST = 2'd3;

   typedef enum logic [1:0] {
      ACT_CLEAR = 2'd0,
      ACT_TRAIN = 2'd1,
      ACT_QUERY = 2'd2,
      ACT_NONE  = 2'd3
   } action_type;

   typedef enum logic [0:0] {
      CSR_K_NEAREST     = 1'b0,
      CSR_FEATURE_COUNT = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'd0,
      ST_SCAN  = 2'd1,
      ST_DRAIN = 2'd2,
      ST_VOTE  = 2'd3
   } state_type;

   typedef struct packed {
      action_type        action;
      logic signed [15:0] feature_value;
      logic [3:0]        class_label;
   } req_type;

   typedef struct packed {
      logic [3:0] winning_label;
      logic [4:0] winning_votes;
      logic       store_empty;
   } rsp_type;

   typedef struct packed {
      logic issue;
      logic first;
      logic rank;
   } scan_ctl_type;

   function automatic int dist_bits(input int fb, input int mf);
      int full;
      full = 2 * (fb + 1) + $clog2(mf + 1);
      return (full > 64) ? 64 : full;
   endfunction

   function automatic logic [16*LABEL_SLOT-1:0] label_map(input int n);
      logic [16*LABEL_SLOT-1:0] map;
      int r;
      map = '0;
      for (int v = 0; v < 16; v++) begin
         r = v;
         while (r >= n) r = r - n;
         map[v*LABEL_SLOT +: LABEL_SLOT] = LABEL_SLOT'(r);
      end
      return map;
   endfunction

endpackage
`default_nettype wire

@@ design/knn_dist_pipe.sv @@
// Sample store and distance pipeline: feature, label/length and distance memories,
// read-modify-write of one sample distance per cycle. Depends on knn_pkg.
`default_nettype none
module knn_dist_pipe import knn_pkg::*; #(
   parameter int MAX_SAMPLES  = DEF_MAX_SAMPLES,
   parameter int MAX_FEATURES = DEF_MAX_FEATURES,
   parameter int NUM_CLASSES  = DEF_NUM_CLASSES,
   parameter int FEATURE_BITS = DEF_FEATURE_BITS,
   localparam int IDX_BITS   = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1,
   localparam int POS_BITS   = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1,
   localparam int LEN_BITS   = $clog2(MAX_FEATURES + 1),
   localparam int CLASS_BITS = $clog2(NUM_CLASSES),
   localparam int DIST_BITS  = dist_bits(FEATURE_BITS, MAX_FEATURES)
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    train_we,
   input  wire logic [IDX_BITS-1:0]     train_sample,
   input  wire logic [POS_BITS-1:0]     train_pos,
   input  wire logic [FEATURE_BITS-1:0] train_value,
   input  wire logic                    meta_we,
   input  wire logic [IDX_BITS-1:0]     meta_sample,
   input  wire logic [CLASS_BITS-1:0]   meta_label,
   input  wire logic [LEN_BITS-1:0]     meta_len,
   input  wire scan_ctl_type            scan,
   input  wire logic [IDX_BITS-1:0]     scan_sample,
   input  wire logic [POS_BITS-1:0]     scan_pos,
   input  wire logic [FEATURE_BITS-1:0] query_value,
   output logic                         res_valid,
   output logic [DIST_BITS-1:0]         res_dist,
   output logic [CLASS_BITS-1:0]        res_label
);

   localparam int MAG_BITS  = FEATURE_BITS + 1;
   localparam int SQ_BITS   = 2 * MAG_BITS;
   localparam int META_BITS = CLASS_BITS + LEN_BITS;

   logic [FEATURE_BITS-1:0] feat_mem [MAX_SAMPLES << POS_BITS];
   logic [META_BITS-1:0]    meta_mem [MAX_SAMPLES];
   logic [DIST_BITS-1:0]    dist_mem [MAX_SAMPLES];

   logic [FEATURE_BITS-1:0] feat_rd_ff;
   logic [META_BITS-1:0]    meta_rd_ff;
   logic [DIST_BITS-1:0]    dist_rd_ff;
   logic                    s1_valid_ff, s2_valid_ff, s3_valid_ff, res_valid_ff;
   logic [IDX_BITS-1:0]     s1_idx_ff, s2_idx_ff, s3_idx_ff;
   logic [DIST_BITS-1:0]    s2_old_ff, s3_old_ff, res_dist_ff;
   logic [CLASS_BITS-1:0]   s2_label_ff, s3_label_ff, res_label_ff;
   logic [MAG_BITS-1:0]     mag_ff;
   logic [DIST_BITS-1:0]    sq_ff;

   logic [FEATURE_BITS-1:0] feat_sel;
   logic [MAG_BITS-1:0]     diff;
   logic [MAG_BITS-1:0]     mag_in;
   logic [SQ_BITS-1:0]      prod;
   logic [DIST_BITS-1:0]    sq_in;
   logic [DIST_BITS:0]      sum_wide;
   logic [DIST_BITS-1:0]    sum_in;

   always_ff @(posedge clock) begin
      if (train_we) feat_mem[{train_sample, train_pos}] <= train_value;
      feat_rd_ff <= feat_mem[{scan_sample, scan_pos}];
   end

   always_ff @(posedge clock) begin
      if (meta_we) meta_mem[meta_sample] <= {meta_label, meta_len};
      meta_rd_ff <= meta_mem[scan_sample];
   end

   always_ff @(posedge clock) begin
      if (s3_valid_ff) dist_mem[s3_idx_ff] <= sum_in;
      dist_rd_ff <= dist_mem[scan_sample];
   end

   always_comb begin
      feat_sel = (LEN_BITS'(scan_pos) < meta_rd_ff[LEN_BITS-1:0]) ? feat_rd_ff : '0;
      diff     = {query_value[FEATURE_BITS-1], query_value}
               - {feat_sel[FEATURE_BITS-1], feat_sel};
      mag_in   = diff[MAG_BITS-1] ? (~diff + 1'b1) : diff;
      prod     = mag_ff * mag_ff;
      sq_in    = ((prod >> DIST_BITS) != '0) ? '1 : DIST_BITS'(prod);
      sum_wide = {1'b0, s3_old_ff} + {1'b0, sq_ff};
      sum_in   = scan.first ? sq_ff
               : (sum_wide[DIST_BITS] ? '1 : sum_wide[DIST_BITS-1:0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         res_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= scan.issue;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         res_valid_ff <= s3_valid_ff && scan.rank;
      end
   end

   always_ff @(posedge clock) begin
      s1_idx_ff    <= scan_sample;
      s2_idx_ff    <= s1_idx_ff;
      s3_idx_ff    <= s2_idx_ff;
      mag_ff       <= mag_in;
      s2_old_ff    <= dist_rd_ff;
      s2_label_ff  <= meta_rd_ff[META_BITS-1:LEN_BITS];
      sq_ff        <= sq_in;
      s3_old_ff    <= s2_old_ff;
      s3_label_ff  <= s2_label_ff;
      res_dist_ff  <= sum_in;
      res_label_ff <= s3_label_ff;
   end

   assign res_valid = res_valid_ff;
   assign res_dist  = res_dist_ff;
   assign res_label = res_label_ff;

endmodule
`default_nettype wire

@@ design/knn_rank_vote.sv @@
// Nearest-sample list with parallel sorted insertion, then a class-by-class
// vote count with a running maximum. Depends on knn_pkg.
`default_nettype none
module knn_rank_vote import knn_pkg::*; #(
   parameter int MAX_K        = DEF_MAX_K,
   parameter int NUM_CLASSES  = DEF_NUM_CLASSES,
   parameter int MAX_FEATURES = DEF_MAX_FEATURES,
   parameter int FEATURE_BITS = DEF_FEATURE_BITS,
   localparam int K_BITS     = $clog2(MAX_K + 1),
   localparam int CLASS_BITS = $clog2(NUM_CLASSES),
   localparam int DIST_BITS  = dist_bits(FEATURE_BITS, MAX_FEATURES)
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  rank_clear,
   input  wire logic [K_BITS-1:0]     k_eff,
   input  wire logic                  res_valid,
   input  wire logic [DIST_BITS-1:0]  res_dist,
   input  wire logic [CLASS_BITS-1:0] res_label,
   input  wire logic                  vote_en,
   output logic                       vote_done,
   output logic [CLASS_BITS-1:0]      win_label,
   output logic [K_BITS-1:0]          win_votes
);

   logic [DIST_BITS-1:0]  best_dist_ff  [MAX_K];
   logic [CLASS_BITS-1:0] best_label_ff [MAX_K];
   logic [MAX_K-1:0]      slot_valid_ff, slot_valid_in;
   logic [MAX_K-1:0]      lt;
   logic [CLASS_BITS-1:0] cls_ff;
   logic [CLASS_BITS-1:0] win_ff;
   logic [K_BITS-1:0]     votes_ff;
   logic [K_BITS-1:0]     tally;
   logic                  more;

   always_comb begin
      for (int j = 0; j < MAX_K; j++) begin
         lt[j] = (32'(j) < 32'(k_eff))
              && (!slot_valid_ff[j] || (res_dist < best_dist_ff[j]));
      end
      for (int j = 0; j < MAX_K; j++) begin
         if (!lt[j]) begin
            slot_valid_in[j] = slot_valid_ff[j];
         end else if (j == 0) begin
            slot_valid_in[j] = 1'b1;
         end else begin
            slot_valid_in[j] = lt[j-1] ? slot_valid_ff[j-1] : 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || rank_clear) begin
         slot_valid_ff <= '0;
      end else if (res_valid) begin
         slot_valid_ff <= slot_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) begin
         for (int j = 0; j < MAX_K; j++) begin
            if (lt[j]) begin
               if (j == 0 || !lt[j-1]) begin
                  best_dist_ff[j]  <= res_dist;
                  best_label_ff[j] <= res_label;
               end else begin
                  best_dist_ff[j]  <= best_dist_ff[j-1];
                  best_label_ff[j] <= best_label_ff[j-1];
               end
            end
         end
      end
   end

   always_comb begin
      tally = '0;
      for (int j = 0; j < MAX_K; j++) begin
         tally = tally + K_BITS'(slot_valid_ff[j] && (best_label_ff[j] == cls_ff));
      end
      more      = tally > votes_ff;
      vote_done = vote_en && (cls_ff == CLASS_BITS'(NUM_CLASSES - 1));
      win_label = more ? cls_ff : win_ff;
      win_votes = more ? tally : votes_ff;
   end

   always_ff @(posedge clock) begin
      if (reset || !vote_en) begin
         cls_ff   <= '0;
         win_ff   <= '0;
         votes_ff <= '0;
      end else begin
         cls_ff   <= cls_ff + 1'b1;
         win_ff   <= win_label;
         votes_ff <= win_votes;
      end
   end

endmodule
`default_nettype wire

@@ design/knn_majority_classifier.sv @@
// Top level of the k-nearest-neighbor classifier: command port, register port,
// controller, and the knn_dist_pipe and knn_rank_vote units. Depends on knn_pkg.
//
// Clear, training features and unused actions take one cycle each; busy stays low.
// A query feature takes sample_count + 5 cycles: one sample distance is read,
// updated and written back per cycle through the distance memory, then the
// pipeline drains. The last feature of a query adds NUM_CLASSES cycles of vote
// counting, after which the result strobes on rsp_valid for one cycle and must be
// taken then. With an empty store, a last query feature answers at once.
`default_nettype none
module knn_majority_classifier import knn_pkg::*; #(
   parameter int MAX_SAMPLES  = DEF_MAX_SAMPLES,
   parameter int MAX_FEATURES = DEF_MAX_FEATURES,
   parameter int MAX_K        = DEF_MAX_K,
   parameter int NUM_CLASSES  = DEF_NUM_CLASSES,
   parameter int FEATURE_BITS = DEF_FEATURE_BITS
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   output logic                          busy,
   input  wire req_type                  req_item,
   output logic                          rsp_valid,
   output rsp_type                       rsp_item,
   input  wire logic                     csr_we,
   input  wire csr_index_type            csr_index,
   input  wire logic [CSR_DATA_BITS-1:0] csr_data
);

   localparam int IDX_BITS   = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
   localparam int POS_BITS   = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
   localparam int LEN_BITS   = $clog2(MAX_FEATURES + 1);
   localparam int CNT_BITS   = $clog2(MAX_SAMPLES + 1);
   localparam int K_BITS     = $clog2(MAX_K + 1);
   localparam int CLASS_BITS = $clog2(NUM_CLASSES);
   localparam int DIST_BITS  = dist_bits(FEATURE_BITS, MAX_FEATURES);
   localparam logic [16*LABEL_SLOT-1:0] LABEL_MAP = label_map(NUM_CLASSES);

   state_type               state_ff, state_in;
   logic [K_REG_BITS-1:0]   k_reg_ff;
   logic [FC_REG_BITS-1:0]  fc_reg_ff;
   logic [CNT_BITS-1:0]     count_ff, count_in;
   logic [POS_BITS-1:0]     pos_ff, pos_in;
   action_type              kind_ff, kind_in;
   logic [CLASS_BITS-1:0]   label_ff, label_in;
   logic [FEATURE_BITS-1:0] q_ff, q_in;
   logic [POS_BITS-1:0]     qpos_ff, qpos_in;
   logic                    qfirst_ff, qfirst_in;
   logic                    qrank_ff, qrank_in;
   logic [K_BITS-1:0]       k_eff_ff, k_eff_in;
   logic [IDX_BITS-1:0]     scan_idx_ff, scan_idx_in;
   logic [DRAIN_BITS-1:0]   drain_ff, drain_in;
   rsp_type                 rsp_ff, rsp_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   logic                    accept;
   logic [POS_BITS-1:0]     pos_eff;
   logic [LEN_BITS-1:0]     fc_eff;
   logic                    last;
   logic [FEATURE_BITS-1:0] fv_raw;
   logic [CLASS_BITS-1:0]   label_mod;
   logic [CLASS_BITS-1:0]   label_sel;
   logic                    room;
   logic                    scan_last;
   logic                    train_we, meta_we, rank_clear, vote_en, vote_done;
   scan_ctl_type            scan;
   logic                    res_valid;
   logic [DIST_BITS-1:0]    res_dist;
   logic [CLASS_BITS-1:0]   res_label;
   logic [CLASS_BITS-1:0]   win_label;
   logic [K_BITS-1:0]       win_votes;
   int                      k_clamp;

   always_comb begin
      accept    = start && (state_ff == ST_IDLE);
      fc_eff    = (fc_reg_ff == '0) ? LEN_BITS'(1)
                : ((32'(fc_reg_ff) > MAX_FEATURES) ? LEN_BITS'(MAX_FEATURES)
                                                   : LEN_BITS'(fc_reg_ff));
      pos_eff   = ((pos_ff != '0) && (kind_ff != req_item.action)) ? '0 : pos_ff;
      last      = (32'(pos_eff) + 1) >= 32'(fc_eff);
      fv_raw    = FEATURE_BITS'($unsigned(req_item.feature_value));
      label_mod = LABEL_MAP[{req_item.class_label, 3'b000} +: CLASS_BITS];
      label_sel = (pos_eff == '0) ? label_mod : label_ff;
      room      = 32'(count_ff) < MAX_SAMPLES;
      scan_last = (32'(scan_idx_ff) + 1) == 32'(count_ff);
      k_clamp   = (k_reg_ff == '0) ? 1 : ((32'(k_reg_ff) > MAX_K) ? MAX_K : 32'(k_reg_ff));
      if (k_clamp > 32'(count_ff)) k_clamp = 32'(count_ff);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_item.action == ACT_QUERY) && (count_ff != '0)) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_last) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (drain_ff == DRAIN_LAST) state_in = qrank_ff ? ST_VOTE : ST_IDLE;
         end
         ST_VOTE: begin
            if (vote_done) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      busy       = state_ff != ST_IDLE;
      scan.issue = state_ff == ST_SCAN;
      scan.first = qfirst_ff;
      scan.rank  = qrank_ff;
      vote_en    = state_ff == ST_VOTE;
      train_we   = accept && (req_item.action == ACT_TRAIN) && room;
      meta_we    = train_we && last;
      rank_clear = accept && (req_item.action == ACT_QUERY) && last && (count_ff != '0);
   end

   always_comb begin
      count_in     = count_ff;
      pos_in       = pos_ff;
      kind_in      = kind_ff;
      label_in     = label_ff;
      q_in         = q_ff;
      qpos_in      = qpos_ff;
      qfirst_in    = qfirst_ff;
      qrank_in     = qrank_ff;
      k_eff_in     = k_eff_ff;
      scan_idx_in  = (state_ff == ST_SCAN) ? scan_idx_ff + 1'b1 : scan_idx_ff;
      drain_in     = (state_ff == ST_DRAIN) ? drain_ff + 1'b1 : '0;
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;
      if (accept) begin
         case (req_item.action)
            ACT_CLEAR: begin
               count_in = '0;
               pos_in   = '0;
               kind_in  = ACT_CLEAR;
            end
            ACT_TRAIN: begin
               kind_in  = ACT_TRAIN;
               pos_in   = last ? '0 : pos_eff + 1'b1;
               label_in = label_sel;
               if (room && last) count_in = count_ff + 1'b1;
            end
            ACT_QUERY: begin
               kind_in     = ACT_QUERY;
               pos_in      = last ? '0 : pos_eff + 1'b1;
               q_in        = fv_raw;
               qpos_in     = pos_eff;
               qfirst_in   = pos_eff == '0;
               qrank_in    = last;
               k_eff_in    = K_BITS'(k_clamp);
               scan_idx_in = '0;
               if ((count_ff == '0) && last) begin
                  rsp_in.winning_label = '0;
                  rsp_in.winning_votes = '0;
                  rsp_in.store_empty   = 1'b1;
                  rsp_valid_in         = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
      if (vote_done) begin
         rsp_in.winning_label = 4'(win_label);
         rsp_in.winning_votes = 5'(win_votes);
         rsp_in.store_empty   = 1'b0;
         rsp_valid_in         = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         k_reg_ff     <= K_REG_BITS'(1);
         fc_reg_ff    <= FC_REG_BITS'(64);
         count_ff     <= '0;
         pos_ff       <= '0;
         kind_ff      <= ACT_CLEAR;
         drain_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pos_ff       <= pos_in;
         kind_ff      <= kind_in;
         drain_ff     <= drain_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we && (csr_index == CSR_K_NEAREST)) k_reg_ff <= csr_data[K_REG_BITS-1:0];
         if (csr_we && (csr_index == CSR_FEATURE_COUNT)) fc_reg_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      label_ff    <= label_in;
      q_ff        <= q_in;
      qpos_ff     <= qpos_in;
      qfirst_ff   <= qfirst_in;
      qrank_ff    <= qrank_in;
      k_eff_ff    <= k_eff_in;
      scan_idx_ff <= scan_idx_in;
      rsp_ff      <= rsp_in;
   end

   knn_dist_pipe #(
      .MAX_SAMPLES  (MAX_SAMPLES),
      .MAX_FEATURES (MAX_FEATURES),
      .NUM_CLASSES  (NUM_CLASSES),
      .FEATURE_BITS (FEATURE_BITS)
   ) u_dist (
      .clock        (clock),
      .reset        (reset),
      .train_we     (train_we),
      .train_sample (count_ff[IDX_BITS-1:0]),
      .train_pos    (pos_eff),
      .train_value  (fv_raw),
      .meta_we      (meta_we),
      .meta_sample  (count_ff[IDX_BITS-1:0]),
      .meta_label   (label_sel),
      .meta_len     (LEN_BITS'(32'(pos_eff) + 1)),
      .scan         (scan),
      .scan_sample  (scan_idx_ff),
      .scan_pos     (qpos_ff),
      .query_value  (q_ff),
      .res_valid    (res_valid),
      .res_dist     (res_dist),
      .res_label    (res_label)
   );

   knn_rank_vote #(
      .MAX_K        (MAX_K),
      .NUM_CLASSES  (NUM_CLASSES),
      .MAX_FEATURES (MAX_FEATURES),
      .FEATURE_BITS (FEATURE_BITS)
   ) u_rank (
      .clock      (clock),
      .reset      (reset),
      .rank_clear (rank_clear),
      .k_eff      (k_eff_ff),
      .res_valid  (res_valid),
      .res_dist   (res_dist),
      .res_label  (res_label),
      .vote_en    (vote_en),
      .vote_done  (vote_done),
      .win_label  (win_label),
      .win_votes  (win_votes)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule
`default_nettype wire

@@ design/knn_checker.sv @@
// Port-level checks for the k-nearest-neighbor classifier and their bind.
// Depends on knn_pkg and knn_majority_classifier.
`default_nettype none
module knn_checker import knn_pkg::*; (
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    start,
   input wire logic    busy,
   input wire req_type req_item,
   input wire logic    rsp_valid,
   input wire rsp_type rsp_item
);

   a_reset_idle: assert property (@(posedge clock) reset |=> !busy && !rsp_valid)
      else $error("block not idle after reset");

   a_train_quick: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_item.action == ACT_TRAIN || req_item.action == ACT_CLEAR)
      |=> !busy && !rsp_valid)
      else $error("store transfer did not complete in one cycle");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.store_empty
      |-> rsp_item.winning_label == 4'd0 && rsp_item.winning_votes == 5'd0)
      else $error("empty store result not zero");

   a_votes_present: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_item.store_empty |-> rsp_item.winning_votes != 5'd0)
      else $error("classified result without votes");

endmodule

bind knn_majority_classifier knn_checker u_knn_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_item  (req_item),
   .rsp_valid (rsp_valid),
   .rsp_item  (rsp_item)
);
`default_nettype wire

@@ tb/knn_majority_classifier_tb.sv @@
// Self-checking testbench for knn_majority_classifier: directed and random training,
// query, clear and register traffic checked against a built-in predictor.
// Depends on knn_pkg and the knn_majority_classifier RTL.
`default_nettype none
module knn_majority_classifier_tb;
   import knn_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SAMPLE_DEPTH = DEF_MAX_SAMPLES;
   localparam int FEATURE_DEPTH = DEF_MAX_FEATURES;
   localparam int VOTER_DEPTH = DEF_MAX_K;
   localparam int LABEL_DEPTH = DEF_NUM_CLASSES;
   localparam int STALL_LIMIT = 20000;
   localparam int ITEM_TARGET = 580;

   class knn_scoreboard;
      logic signed [15:0] sample_feat[SAMPLE_DEPTH][FEATURE_DEPTH];
      logic [3:0]         sample_lbl[SAMPLE_DEPTH];
      longint unsigned    sample_dist[SAMPLE_DEPTH];
      int                 stored;
      int                 position;
      action_type         vec_kind;
      int                 k_reg;
      int                 fc_reg;
      rsp_type            vote_q[$];
      int                 errors;
      int                 answers;
      int                 empty_answers;

      function new();
         stored = 0;
         position = 0;
         vec_kind = ACT_CLEAR;
         k_reg = 1;
         fc_reg = 64;
         errors = 0;
         answers = 0;
         empty_answers = 0;
      endfunction

      function void write_reg(csr_index_type idx, int value);
         if (idx == CSR_K_NEAREST) k_reg = value & 'h1f;
         else fc_reg = value & 'h7f;
      endfunction

      function rsp_type vote();
         rsp_type            r;
         int                 k;
         int                 filled;
         int                 j;
         int                 win;
         int                 nearest_idx[VOTER_DEPTH];
         longint unsigned    nearest_dist[VOTER_DEPTH];
         int                 tally[LABEL_DEPTH];
         r = '0;
         if (stored == 0) begin
            r.store_empty = 1'b1;
            return r;
         end
         k = (k_reg == 0) ? 1 : ((k_reg > VOTER_DEPTH) ? VOTER_DEPTH : k_reg);
         if (k > stored) k = stored;
         filled = 0;
         for (int i = 0; i < stored; i++) begin
            if (filled < k) begin
               j = filled;
               filled++;
            end else if (sample_dist[i] < nearest_dist[k-1]) begin
               j = k - 1;
            end else begin
               continue;
            end
            while (j > 0 && nearest_dist[j-1] > sample_dist[i]) begin
               nearest_dist[j] = nearest_dist[j-1];
               nearest_idx[j] = nearest_idx[j-1];
               j--;
            end
            nearest_dist[j] = sample_dist[i];
            nearest_idx[j] = i;
         end
         for (int c = 0; c < LABEL_DEPTH; c++) tally[c] = 0;
         for (int i = 0; i < k; i++) tally[sample_lbl[nearest_idx[i]]]++;
         win = 0;
         for (int c = 1; c < LABEL_DEPTH; c++)
            if (tally[c] > tally[win]) win = c;
         r.winning_label = win[3:0];
         r.winning_votes = tally[win][4:0];
         return r;
      endfunction

      function void note_input(req_type r);
         int              fc;
         int              p;
         bit              last;
         longint          diff;
         longint unsigned sq;
         fc = (fc_reg == 0) ? 1 : ((fc_reg > FEATURE_DEPTH) ? FEATURE_DEPTH : fc_reg);
         if (r.action == ACT_CLEAR) begin
            stored = 0;
            position = 0;
            vec_kind = ACT_CLEAR;
            return;
         end
         if (r.action == ACT_NONE) return;
         if (position != 0 && vec_kind != r.action) position = 0;
         vec_kind = r.action;
         p = (position >= FEATURE_DEPTH) ? FEATURE_DEPTH - 1 : position;
         last = (p + 1 >= fc);
         position = last ? 0 : p + 1;
         if (r.action == ACT_TRAIN) begin
            if (stored < SAMPLE_DEPTH) begin
               if (p == 0) begin
                  for (int f = 0; f < FEATURE_DEPTH; f++) sample_feat[stored][f] = '0;
                  sample_lbl[stored] = r.class_label;
               end
               sample_feat[stored][p] = r.feature_value;
               if (last) stored++;
            end
            return;
         end
         for (int i = 0; i < stored; i++) begin
            diff = longint'(sample_feat[i][p]) - longint'(r.feature_value);
            if (diff < 0) diff = -diff;
            sq = longint'(diff) * longint'(diff);
            sample_dist[i] = (p == 0) ? sq : sample_dist[i] + sq;
         end
         if (last) vote_q.insert(vote_q.size(), vote());
      endfunction

      function void check_result(rsp_type r);
         rsp_type e;
         if (vote_q.size() == 0) begin
            $error("unexpected result: label %0d votes %0d empty %0d",
                   r.winning_label, r.winning_votes, r.store_empty);
            errors++;
            return;
         end
         e = vote_q.pop_front();
         answers++;
         if (e.store_empty) empty_answers++;
         if (r.winning_label !== e.winning_label) begin
            $error("winning_label: expected %0d, actual %0d", e.winning_label, r.winning_label);
            errors++;
         end
         if (r.winning_votes !== e.winning_votes) begin
            $error("winning_votes: expected %0d, actual %0d", e.winning_votes, r.winning_votes);
            errors++;
         end
         if (r.store_empty !== e.store_empty) begin
            $error("store_empty: expected %0d, actual %0d", e.store_empty, r.store_empty);
            errors++;
         end
      endfunction
   endclass

   logic          clock;
   logic          reset;
   logic          start;
   logic          busy;
   req_type       req_item;
   logic          rsp_valid;
   rsp_type       rsp_item;
   logic          csr_we;
   csr_index_type csr_index;
   logic [CSR_DATA_BITS-1:0] csr_data;

   knn_scoreboard sb;
   int            items_sent;
   int            burst_left;
   bit            gaps_on;
   int            fc_now;
   int            stall_count;

   knn_majority_classifier uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_item(req_item),
      .rsp_valid(rsp_valid), .rsp_item(rsp_item), .csr_we(csr_we), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) sb.check_result(rsp_item);
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stall_count <= 0;
      end else if (stall_count >= STALL_LIMIT) begin
         $display("knn_majority_classifier_tb: done, errors");
         $finish;
      end else begin
         stall_count <= stall_count + 1;
      end
   end

   task automatic send(action_type act, logic signed [15:0] value, logic [3:0] lbl);
      req_type r;
      r.action = act;
      r.feature_value = value;
      r.class_label = lbl;
      @(negedge clock);
      start = 1'b1;
      req_item = r;
      do @(posedge clock); while (busy);
      sb.note_input(r);
      items_sent++;
      if (gaps_on) begin
         burst_left--;
         if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 12);
            @(negedge clock);
            start = 1'b0;
            repeat ($urandom_range(0, 5)) @(negedge clock);
         end
      end
   endtask

   task automatic wait_quiet();
      @(negedge clock);
      start = 1'b0;
      while (sb.vote_q.size() != 0) @(posedge clock);
      while (busy) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_regs(int k, int fc);
      wait_quiet();
      @(negedge clock);
      csr_we = 1'b1;
      csr_index = CSR_K_NEAREST;
      csr_data = CSR_DATA_BITS'(k);
      sb.write_reg(CSR_K_NEAREST, k);
      @(negedge clock);
      csr_index = CSR_FEATURE_COUNT;
      csr_data = CSR_DATA_BITS'(fc);
      sb.write_reg(CSR_FEATURE_COUNT, fc);
      @(negedge clock);
      csr_we = 1'b0;
      fc_now = (fc == 0) ? 1 : ((fc > FEATURE_DEPTH) ? FEATURE_DEPTH : fc);
      send(ACT_CLEAR, 16'($urandom), 4'($urandom));
   endtask

   function automatic logic signed [15:0] pick_value(int spread);
      case (spread)
         0: return 16'($urandom);
         3: return ($urandom_range(0, 1) == 1) ? 16'sh7fff : 16'sh8000;
         default: return 16'($signed($urandom_range(0, 8)) - 4);
      endcase
   endfunction

   task automatic vector(action_type act, int n);
      int   spread;
      logic [3:0] lbl;
      spread = $urandom_range(0, 3);
      lbl = 4'($urandom);
      for (int f = 0; f < n; f++) send(act, pick_value(spread), lbl);
   endtask

   initial begin
      int phase_k[8] = '{1, 0, 16, 31, 5, 3, 8, 2};
      int phase_fc[8] = '{1, 127, 64, 3, 0, 2, 8, 4};
      int phase;
      int n;
      sb = new();
      reset = 1'b1;
      start = 1'b0;
      req_item = '0;
      csr_we = 1'b0;
      csr_index = CSR_K_NEAREST;
      csr_data = '0;
      items_sent = 0;
      burst_left = 4;
      gaps_on = 1'b0;
      fc_now = FEATURE_DEPTH;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      write_regs(3, 2);
      vector(ACT_QUERY, 2);
      send(ACT_TRAIN, 16'sh7fff, 4'd5);
      send(ACT_TRAIN, 16'sh8000, 4'd5);
      send(ACT_TRAIN, 16'sh8000, 4'd2);
      send(ACT_TRAIN, 16'sh7fff, 4'd2);
      send(ACT_TRAIN, 16'sh0000, 4'd15);
      send(ACT_TRAIN, 16'sh0000, 4'd15);
      send(ACT_QUERY, 16'sh7fff, 4'd0);
      send(ACT_QUERY, 16'sh8000, 4'd0);
      send(ACT_NONE, 16'sh7fff, 4'hf);
      send(ACT_TRAIN, 16'sh1234, 4'd9);
      send(ACT_QUERY, 16'sh0000, 4'd0);
      send(ACT_QUERY, 16'sh0000, 4'd0);
      send(ACT_TRAIN, 16'sh0000, 4'd0);
      send(ACT_TRAIN, 16'sh0000, 4'd0);
      send(ACT_QUERY, 16'sh0000, 4'd0);
      send(ACT_QUERY, 16'sh0000, 4'd0);
      send(ACT_CLEAR, 16'sh0000, 4'd0);
      vector(ACT_QUERY, 2);

      gaps_on = 1'b1;
      phase = 0;
      while (items_sent < ITEM_TARGET) begin
         gaps_on = (phase % 3 != 2);
         write_regs(phase_k[phase % 8], phase_fc[phase % 8]);
         n = (fc_now > 8) ? $urandom_range(1, 4) : $urandom_range(1, 14);
         repeat (n) vector(ACT_TRAIN, fc_now);
         repeat ((fc_now > 8) ? 2 : $urandom_range(4, 10)) begin
            if (items_sent >= ITEM_TARGET) break;
            case ($urandom_range(0, 9))
               0: send(ACT_NONE, 16'($urandom), 4'($urandom));
               1: vector(ACT_TRAIN, $urandom_range(1, fc_now));
               2: vector(ACT_QUERY, $urandom_range(1, fc_now));
               3: send(ACT_CLEAR, 16'($urandom), 4'($urandom));
               default: ;
            endcase
            vector(ACT_QUERY, fc_now);
            if (phase == 1) wait_quiet();
         end
         phase++;
      end

      wait_quiet();
      $display("Covered %0d transfers in %0d register phases; %0d answers checked (%0d empty).",
               items_sent, phase + 1, sb.answers, sb.empty_answers);
      if (sb.errors == 0 && sb.vote_q.size() == 0) begin
         $display("knn_majority_classifier_tb: done, clean");
      end else begin
         $display("knn_majority_classifier_tb: done, errors");
      end
      $finish;
   end

endmodule
`default_nettype wire
